/* hdl/qrs_pkg.sv */
// Shared widths, limits and stage records for the quadratic root solver.
package qrs_pkg;

   localparam int COEF_W    = 16;
   localparam int ROOT_FRAC = 16;
   localparam int OUT_W     = 32;
   localparam int IMAG_W    = 31;

   // The discriminant magnitude stays below 5 * 2^(2*COEF_W-2).
   localparam int DMAG_W = 2 * COEF_W + 1;
   localparam int DS_W   = DMAG_W + 1;
   localparam int ROOT_W = (DMAG_W + 2 * ROOT_FRAC + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   localparam int NB_W   = COEF_W - 1 + ROOT_FRAC;
   localparam int NUM_W  = ((NB_W > ROOT_W) ? NB_W : ROOT_W) + 1;
   localparam int DEN_W  = COEF_W + 1;
   localparam int DV_W   = DEN_W + 1;
   localparam int DIVD_W = NUM_W + 2;

   localparam logic [DIVD_W-1:0] POS_LIM =
      {{(DIVD_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic [DIVD_W-1:0] NEG_LIM = POS_LIM + DIVD_W'(1);
   localparam logic [DIVD_W-1:0] IMAG_LIM =
      {{(DIVD_W - IMAG_W){1'b0}}, {IMAG_W{1'b1}}};

   typedef struct packed {
      logic                     valid;
      logic                     lead_zero;
      logic                     neg;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
   } sq_side_type;

   typedef struct packed {
      logic            valid;
      logic            lead_zero;
      logic            neg;
      logic            sign1;
      logic            sign2;
      logic [DV_W-1:0] divisor;
   } dv_side_type;

endpackage

/* hdl/qrs_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cycle.
module qrs_sqrt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  qrs_pkg::sq_side_type      side_i,
   input  logic [qrs_pkg::RAD_W-1:0]  rad_i,
   input  logic [qrs_pkg::REM_W-1:0]  rem_i,
   input  logic [qrs_pkg::ROOT_W-1:0] root_i,
   output qrs_pkg::sq_side_type      side_o,
   output logic [qrs_pkg::RAD_W-1:0]  rad_o,
   output logic [qrs_pkg::REM_W-1:0]  rem_o,
   output logic [qrs_pkg::ROOT_W-1:0] root_o
);
   import qrs_pkg::*;

   sq_side_type       side_ff;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  rem_wide;
   logic [REM_W+1:0]  trial;
   logic              take;

   always_comb begin
      rem_wide = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial    = {{(REM_W - ROOT_W){1'b0}}, root_i, 2'b01};
      take     = (rem_wide >= trial);
      rem_in   = take ? REM_W'(rem_wide - trial) : REM_W'(rem_wide);
      root_in  = {root_i[ROOT_W-2:0], take};
      rad_in   = rad_i << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_i.valid;
      end
      side_ff.lead_zero <= side_i.lead_zero;
      side_ff.neg       <= side_i.neg;
      side_ff.a         <= side_i.a;
      side_ff.b         <= side_i.b;
      rad_ff            <= rad_in;
      rem_ff            <= rem_in;
      root_ff           <= root_in;
   end

   assign side_o = side_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

/* hdl/qrs_div_cell.sv */
// One cell of the two-lane divider chain: one quotient bit per lane per cycle.
module qrs_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  qrs_pkg::dv_side_type      side_i,
   input  logic [qrs_pkg::DIVD_W-1:0] n1_i,
   input  logic [qrs_pkg::DIVD_W-1:0] n2_i,
   input  logic [qrs_pkg::DV_W-1:0]   rem1_i,
   input  logic [qrs_pkg::DV_W-1:0]   rem2_i,
   input  logic [qrs_pkg::DIVD_W-1:0] q1_i,
   input  logic [qrs_pkg::DIVD_W-1:0] q2_i,
   output qrs_pkg::dv_side_type      side_o,
   output logic [qrs_pkg::DIVD_W-1:0] n1_o,
   output logic [qrs_pkg::DIVD_W-1:0] n2_o,
   output logic [qrs_pkg::DV_W-1:0]   rem1_o,
   output logic [qrs_pkg::DV_W-1:0]   rem2_o,
   output logic [qrs_pkg::DIVD_W-1:0] q1_o,
   output logic [qrs_pkg::DIVD_W-1:0] q2_o
);
   import qrs_pkg::*;

   dv_side_type       side_ff;
   logic [DIVD_W-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [DV_W-1:0]   rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [DIVD_W-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [DV_W:0]     w1, w2, dvx;
   logic              t1, t2;

   always_comb begin
      dvx     = {1'b0, side_i.divisor};
      w1      = {rem1_i, n1_i[DIVD_W-1]};
      w2      = {rem2_i, n2_i[DIVD_W-1]};
      t1      = (w1 >= dvx);
      t2      = (w2 >= dvx);
      rem1_in = t1 ? DV_W'(w1 - dvx) : DV_W'(w1);
      rem2_in = t2 ? DV_W'(w2 - dvx) : DV_W'(w2);
      q1_in   = {q1_i[DIVD_W-2:0], t1};
      q2_in   = {q2_i[DIVD_W-2:0], t2};
      n1_in   = n1_i << 1;
      n2_in   = n2_i << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_i.valid;
      end
      side_ff.lead_zero <= side_i.lead_zero;
      side_ff.neg       <= side_i.neg;
      side_ff.sign1     <= side_i.sign1;
      side_ff.sign2     <= side_i.sign2;
      side_ff.divisor   <= side_i.divisor;
      n1_ff             <= n1_in;
      n2_ff             <= n2_in;
      rem1_ff           <= rem1_in;
      rem2_ff           <= rem2_in;
      q1_ff             <= q1_in;
      q2_ff             <= q2_in;
   end

   assign side_o = side_ff;
   assign n1_o   = n1_ff;
   assign n2_o   = n2_ff;
   assign rem1_o = rem1_ff;
   assign rem2_o = rem2_ff;
   assign q1_o   = q1_ff;
   assign q2_o   = q2_ff;

endmodule

/* hdl/quadratic_root_solver_core.sv */
// Top level of the quadratic root solver: front stages, cell chains and output stage.
//
// Takes one coefficient set in every cycle (busy stays low) and gives its roots on
// the rsp_ ports, marked by rsp_valid, once the item has passed 76 register
// stages, of which the edge that accepts it loads the first:
// 4 input and discriminant stages, one cell per root bit in the square root
// chain (33), 2 numerator stages, one cell per quotient bit in the divider chain
// (36) and the output register. Items come out in the order they went in, and the
// receiver must take each result in the cycle it is shown.
module quadratic_root_solver_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [qrs_pkg::COEF_W-1:0]  req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]  req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]  req_coef_c,
   output logic                               rsp_valid,
   output logic signed [qrs_pkg::OUT_W-1:0]   rsp_root_one_real,
   output logic signed [qrs_pkg::OUT_W-1:0]   rsp_root_two_real,
   output logic [qrs_pkg::IMAG_W-1:0]         rsp_imag_part,
   output logic                               rsp_is_complex,
   output logic                               rsp_lead_zero,
   output logic                               rsp_overflowed
);
   import qrs_pkg::*;

   // Front stages.
   sq_side_type                s0_side_ff, s1_side_ff, s2_side_ff, s3_side_ff;
   logic signed [COEF_W-1:0]   s0_c_ff;
   logic signed [2*COEF_W-1:0] s1_bb_ff, s1_p_ff;
   logic [DS_W-1:0]            s2_d_ff, s2_d_in;
   logic [DMAG_W-1:0]          s3_dmag_ff, s3_dmag_in;

   // Square root chain.
   sq_side_type       sq_side [0:ROOT_W];
   logic [RAD_W-1:0]  sq_rad  [0:ROOT_W];
   logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root [0:ROOT_W];

   // Numerator stages.
   sq_side_type       n1_side_ff;
   logic [NUM_W:0]    n1_num1_ff, n1_num1_in, n1_num2_ff, n1_num2_in;
   logic [NUM_W:0]    nb, s_ext, b_ext;
   dv_side_type       n2_side_ff, n2_side_in;
   logic [DIVD_W-1:0] n2_n1_ff, n2_n1_in, n2_n2_ff, n2_n2_in;
   logic [NUM_W-1:0]  mag1, mag2;
   logic [DEN_W-1:0]  a_ext, amag, ud;

   // Divider chain.
   dv_side_type       dv_side [0:DIVD_W];
   logic [DIVD_W-1:0] dv_n1   [0:DIVD_W];
   logic [DIVD_W-1:0] dv_n2   [0:DIVD_W];
   logic [DV_W-1:0]   dv_rem1 [0:DIVD_W];
   logic [DV_W-1:0]   dv_rem2 [0:DIVD_W];
   logic [DIVD_W-1:0] dv_q1   [0:DIVD_W];
   logic [DIVD_W-1:0] dv_q2   [0:DIVD_W];

   // Output stage.
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  r1_ff, r1_in, r2_ff, r2_in;
   logic [IMAG_W-1:0] im_ff, im_in;
   logic              cplx_ff, cplx_in, lz_ff, lz_in, ovf_ff, ovf_in;
   logic [DIVD_W-1:0] q1f, q2f;
   dv_side_type       fs;
   logic              ov1, ov2, ovi;
   logic [OUT_W-1:0]  v1, v2;

   assign busy = 1'b0;

   always_comb begin
      s2_d_in = {{2{s1_bb_ff[2*COEF_W-1]}}, s1_bb_ff} - {s1_p_ff, 2'b00};
      s3_dmag_in = s2_d_ff[DS_W-1] ? DMAG_W'(-s2_d_ff) : DMAG_W'(s2_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_side_ff.valid <= 1'b0;
         s1_side_ff.valid <= 1'b0;
         s2_side_ff.valid <= 1'b0;
         s3_side_ff.valid <= 1'b0;
      end else begin
         s0_side_ff.valid <= start & ~busy;
         s1_side_ff.valid <= s0_side_ff.valid;
         s2_side_ff.valid <= s1_side_ff.valid;
         s3_side_ff.valid <= s2_side_ff.valid;
      end
      s0_side_ff.lead_zero <= (req_coef_a == '0);
      s0_side_ff.neg       <= 1'b0;
      s0_side_ff.a         <= req_coef_a;
      s0_side_ff.b         <= req_coef_b;
      s0_c_ff              <= req_coef_c;

      s1_side_ff.lead_zero <= s0_side_ff.lead_zero;
      s1_side_ff.neg       <= s0_side_ff.neg;
      s1_side_ff.a         <= s0_side_ff.a;
      s1_side_ff.b         <= s0_side_ff.b;
      s1_bb_ff             <= s0_side_ff.b * s0_side_ff.b;
      s1_p_ff              <= s0_side_ff.a * s0_c_ff;

      s2_side_ff.lead_zero <= s1_side_ff.lead_zero;
      s2_side_ff.neg       <= s1_side_ff.neg;
      s2_side_ff.a         <= s1_side_ff.a;
      s2_side_ff.b         <= s1_side_ff.b;
      s2_d_ff              <= s2_d_in;

      s3_side_ff.lead_zero <= s2_side_ff.lead_zero;
      s3_side_ff.neg       <= s2_d_ff[DS_W-1];
      s3_side_ff.a         <= s2_side_ff.a;
      s3_side_ff.b         <= s2_side_ff.b;
      s3_dmag_ff           <= s3_dmag_in;
   end

   // The radicand is |D| scaled by 2^(2*ROOT_FRAC) so the root carries ROOT_FRAC
   // fraction bits.
   assign sq_side[0] = s3_side_ff;
   assign sq_rad[0]  = RAD_W'({s3_dmag_ff, {(2 * ROOT_FRAC){1'b0}}});
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (sq_side[k]),
         .rad_i  (sq_rad[k]),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .side_o (sq_side[k+1]),
         .rad_o  (sq_rad[k+1]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1])
      );
   end

   // Real roots take (-b*2^R +/- S); complex roots take -b*2^R on lane one and S
   // on lane two.
   always_comb begin
      b_ext      = {{(NUM_W + 1 - COEF_W){sq_side[ROOT_W].b[COEF_W-1]}}, sq_side[ROOT_W].b};
      nb         = '0 - (b_ext << ROOT_FRAC);
      s_ext      = (NUM_W + 1)'(sq_root[ROOT_W]);
      n1_num1_in = sq_side[ROOT_W].neg ? nb : nb + s_ext;
      n1_num2_in = sq_side[ROOT_W].neg ? s_ext : nb - s_ext;
   end

   always_comb begin
      mag1  = n1_num1_ff[NUM_W] ? NUM_W'(-n1_num1_ff) : NUM_W'(n1_num1_ff);
      mag2  = n1_num2_ff[NUM_W] ? NUM_W'(-n1_num2_ff) : NUM_W'(n1_num2_ff);
      a_ext = {n1_side_ff.a[COEF_W-1], n1_side_ff.a};
      amag  = n1_side_ff.a[COEF_W-1] ? -a_ext : a_ext;
      ud    = {amag[DEN_W-2:0], 1'b0};
      // Rounding to nearest: (2|n| + |d|) / (2|d|).
      n2_n1_in = DIVD_W'({mag1, 1'b0}) + DIVD_W'(ud);
      n2_n2_in = DIVD_W'({mag2, 1'b0}) + DIVD_W'(ud);
      n2_side_in.valid     = n1_side_ff.valid;
      n2_side_in.lead_zero = n1_side_ff.lead_zero;
      n2_side_in.neg       = n1_side_ff.neg;
      n2_side_in.sign1     = n1_num1_ff[NUM_W] ^ n1_side_ff.a[COEF_W-1];
      n2_side_in.sign2     = n1_side_ff.neg ? 1'b0
                             : (n1_num2_ff[NUM_W] ^ n1_side_ff.a[COEF_W-1]);
      n2_side_in.divisor   = {ud, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_side_ff.valid <= 1'b0;
         n2_side_ff.valid <= 1'b0;
      end else begin
         n1_side_ff.valid <= sq_side[ROOT_W].valid;
         n2_side_ff.valid <= n2_side_in.valid;
      end
      n1_side_ff.lead_zero <= sq_side[ROOT_W].lead_zero;
      n1_side_ff.neg       <= sq_side[ROOT_W].neg;
      n1_side_ff.a         <= sq_side[ROOT_W].a;
      n1_side_ff.b         <= sq_side[ROOT_W].b;
      n1_num1_ff           <= n1_num1_in;
      n1_num2_ff           <= n1_num2_in;

      n2_side_ff.lead_zero <= n2_side_in.lead_zero;
      n2_side_ff.neg       <= n2_side_in.neg;
      n2_side_ff.sign1     <= n2_side_in.sign1;
      n2_side_ff.sign2     <= n2_side_in.sign2;
      n2_side_ff.divisor   <= n2_side_in.divisor;
      n2_n1_ff             <= n2_n1_in;
      n2_n2_ff             <= n2_n2_in;
   end

   assign dv_side[0] = n2_side_ff;
   assign dv_n1[0]   = n2_n1_ff;
   assign dv_n2[0]   = n2_n2_ff;
   assign dv_rem1[0] = '0;
   assign dv_rem2[0] = '0;
   assign dv_q1[0]   = '0;
   assign dv_q2[0]   = '0;

   for (genvar k = 0; k < DIVD_W; k++) begin : g_div
      qrs_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (dv_side[k]),
         .n1_i   (dv_n1[k]),
         .n2_i   (dv_n2[k]),
         .rem1_i (dv_rem1[k]),
         .rem2_i (dv_rem2[k]),
         .q1_i   (dv_q1[k]),
         .q2_i   (dv_q2[k]),
         .side_o (dv_side[k+1]),
         .n1_o   (dv_n1[k+1]),
         .n2_o   (dv_n2[k+1]),
         .rem1_o (dv_rem1[k+1]),
         .rem2_o (dv_rem2[k+1]),
         .q1_o   (dv_q1[k+1]),
         .q2_o   (dv_q2[k+1])
      );
   end

   // Signs, saturation and the zero lead coefficient case.
   always_comb begin
      fs  = dv_side[DIVD_W];
      q1f = dv_q1[DIVD_W];
      q2f = dv_q2[DIVD_W];
      ov1 = fs.sign1 ? (q1f > NEG_LIM) : (q1f > POS_LIM);
      ov2 = fs.sign2 ? (q2f > NEG_LIM) : (q2f > POS_LIM);
      ovi = (q2f > IMAG_LIM);
      if (ov1) begin
         v1 = fs.sign1 ? NEG_LIM[OUT_W-1:0] : POS_LIM[OUT_W-1:0];
      end else begin
         v1 = fs.sign1 ? -q1f[OUT_W-1:0] : q1f[OUT_W-1:0];
      end
      if (ov2) begin
         v2 = fs.sign2 ? NEG_LIM[OUT_W-1:0] : POS_LIM[OUT_W-1:0];
      end else begin
         v2 = fs.sign2 ? -q2f[OUT_W-1:0] : q2f[OUT_W-1:0];
      end
      if (fs.lead_zero) begin
         r1_in   = '0;
         r2_in   = '0;
         im_in   = '0;
         cplx_in = 1'b0;
         ovf_in  = 1'b0;
      end else if (fs.neg) begin
         r1_in   = v1;
         r2_in   = v1;
         im_in   = ovi ? IMAG_LIM[IMAG_W-1:0] : q2f[IMAG_W-1:0];
         cplx_in = 1'b1;
         ovf_in  = ov1 | ovi;
      end else begin
         r1_in   = v1;
         r2_in   = v2;
         im_in   = '0;
         cplx_in = 1'b0;
         ovf_in  = ov1 | ov2;
      end
      lz_in = fs.lead_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fs.valid;
      end
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      im_ff   <= im_in;
      cplx_ff <= cplx_in;
      lz_ff   <= lz_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root_one_real = r1_ff;
   assign rsp_root_two_real = r2_ff;
   assign rsp_imag_part     = im_ff;
   assign rsp_is_complex    = cplx_ff;
   assign rsp_lead_zero     = lz_ff;
   assign rsp_overflowed    = ovf_ff;

endmodule
